>>> sv/fep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_pkg: shared types, constants and float helpers
// Single-precision add, multiply and round used by the float pipeline steps.
// ----------------------------------------------------------------------------
package fep_pkg;

  // clamp bound, conversion constants and polynomial coefficients
  localparam logic [31:0] ClampHi = 32'h42B0C0A5;
  localparam logic [31:0] Log2E   = 32'h3FB8AA3B;
  localparam logic [31:0] Ln2     = 32'h3F317218;
  localparam logic [31:0] CoefP0  = 32'h39506967;
  localparam logic [31:0] CoefP1  = 32'h3AB743CE;
  localparam logic [31:0] CoefP2  = 32'h3C088908;
  localparam logic [31:0] CoefP3  = 32'h3D2AA9C1;
  localparam logic [31:0] CoefP4  = 32'h3E2AAAAA;
  localparam logic [31:0] CoefP5  = 32'h3F000000;
  localparam logic [31:0] FpOne   = 32'h3F800000;
  localparam logic [7:0]  ExpBias = 8'h7F;
  localparam int          MantBits = 23;

  // arithmetic steps in pipeline order
  typedef enum logic [4:0] {
    ST_LOG2E, ST_LN2, ST_SUB, ST_SQR,
    ST_M0, ST_A1, ST_M1, ST_A2, ST_M2, ST_A3, ST_M3, ST_A4, ST_M4, ST_A5,
    ST_POLY, ST_ADDG, ST_ADD1, ST_SCALE
  } step_e;

  // unrounded result: value = man * 2^(ex - 127 - 46)
  typedef struct packed {
    logic               sgn;
    logic               inf;
    logic               zero;
    logic signed [11:0] ex;
    logic [48:0]        man;
  } raw_t;

  // per-item working set carried down the pipeline
  typedef struct packed {
    logic [31:0]       x;
    logic [31:0]       t;
    logic [31:0]       fx;
    logic [31:0]       g;
    logic [31:0]       g2;
    logic [31:0]       y;
    logic signed [8:0] n;
  } ctx_t;

  // clamp to the legal range, nan goes to the upper bound
  function automatic logic [31:0] fp_clamp(input logic [31:0] a);
    logic is_nan;
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    if (is_nan) return ClampHi;
    if (a[30:0] > ClampHi[30:0]) return {a[31], ClampHi[30:0]};
    return a;
  endfunction

  // exact product ahead of rounding
  function automatic raw_t fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    raw_t        r;
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {(a[30:23] != 8'd0), a[22:0]};
    mb     = {(b[30:23] != 8'd0), b[22:0]};
    p      = 48'(ma) * 48'(mb);
    r.sgn  = a[31] ^ b[31];
    r.inf  = (a[30:23] == 8'hFF) || (b[30:23] == 8'hFF);
    r.zero = (ma == '0) || (mb == '0);
    r.ex   = $signed(12'({4'b0, ea}) + 12'({4'b0, eb}) - 12'd127);
    r.man  = {1'b0, p};
    return r;
  endfunction

  // aligned sum with sticky jam ahead of rounding
  function automatic raw_t fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic [7:0]  ebg, esm;
    logic [23:0] mbg, msm;
    logic [8:0]  d;
    logic [5:0]  dd;
    logic [48:0] av, bv, sum;
    logic [97:0] w;
    logic        same;
    raw_t        r;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    ebg  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esm  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mbg  = {(big[30:23] != 8'd0), big[22:0]};
    msm  = {(sml[30:23] != 8'd0), sml[22:0]};
    d    = {1'b0, ebg} - {1'b0, esm};
    dd   = (d > 9'd60) ? 6'd60 : d[5:0];
    av   = {2'b0, mbg, 23'b0};
    w    = {2'b0, msm, 23'b0, 49'b0} >> dd;
    bv   = w[97:49];
    bv[0] = bv[0] | (|w[48:0]);
    same = (a[31] == b[31]);
    sum  = same ? (av + bv) : (av - bv);
    r.sgn  = ((sum == '0) && !same) ? 1'b0 : big[31];
    r.inf  = (big[30:23] == 8'hFF);
    r.zero = (sum == '0);
    r.ex   = $signed({4'b0, ebg});
    r.man  = sum;
    return r;
  endfunction

  // normalize and round to nearest even, subnormals kept
  function automatic logic [31:0] fp_round(input raw_t r);
    logic [5:0]         lz;
    logic signed [12:0] en, er, sh, nsh, ef;
    logic [5:0]         amt;
    logic [97:0]        w;
    logic [48:0]        m;
    logic               stk, inc;
    logic [24:0]        q;
    logic [22:0]        frac;
    if (r.inf) return {r.sgn, 8'hFF, 23'b0};
    if (r.zero) return {r.sgn, 31'b0};
    lz = 6'd49;
    for (int i = 0; i < 49; i++) begin
      if (r.man[i]) lz = 6'(48 - i);
    end
    en = $signed({r.ex[11], r.ex}) + 13'sd2 - $signed({7'b0, lz});
    er = (en < 13'sd1) ? 13'sd1 : en;
    sh = $signed({r.ex[11], r.ex}) - er;
    w  = {r.man, 49'b0};
    if (sh >= 13'sd0) begin
      w = w << sh[5:0];
    end else begin
      nsh = -sh;
      amt = (nsh > 13'sd63) ? 6'd63 : nsh[5:0];
      w   = w >> amt;
    end
    m    = w[97:49];
    stk  = (|m[21:0]) | (|w[48:0]);
    inc  = m[22] & (stk | m[23]);
    q    = {1'b0, m[46:23]} + 25'(inc);
    if (q[24]) begin
      ef   = er + 13'sd1;
      frac = '0;
    end else if (q[23]) begin
      ef   = er;
      frac = q[22:0];
    end else begin
      ef   = 13'sd0;
      frac = q[22:0];
    end
    if (ef >= 13'sd255) return {r.sgn, 8'hFF, 23'b0};
    return {r.sgn, ef[7:0], frac};
  endfunction

  // nearest integer of a small float, ties to even
  function automatic logic signed [8:0] fp_rne(input logic [31:0] t);
    logic [7:0]  e;
    logic [4:0]  sh;
    logic [47:0] w;
    logic [8:0]  mag;
    logic        up;
    e = t[30:23];
    if (e < 8'd126) return 9'sd0;
    if (e > 8'd134) e = 8'd134;
    sh  = 5'(8'd150 - e);
    w   = {1'b1, t[22:0], 24'b0} >> sh;
    up  = w[23] & ((|w[22:0]) | w[24]);
    mag = {1'b0, w[31:24]} + 9'(up);
    return t[31] ? $signed(-mag) : $signed(mag);
  endfunction

  // exact integer to float for |n| <= 128
  function automatic logic [31:0] fp_from_int(input logic signed [8:0] n);
    logic [8:0]  mag;
    logic [2:0]  p;
    logic [23:0] f;
    mag = n[8] ? 9'(-n) : 9'(n);
    if (mag == '0) return 32'd0;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) p = 3'(i);
    end
    f = 24'(mag[7:0]) << (5'd23 - {2'b0, p});
    return {n[8], ExpBias + {5'b0, p}, f[22:0]};
  endfunction

  // power of two 2^n built in the exponent field
  function automatic logic [31:0] fp_scale(input logic signed [8:0] n);
    logic signed [9:0] e;
    e = $signed({n[8], n}) + $signed({2'b0, ExpBias});
    if (e <= 10'sd0) return 32'd0;
    if (e > 10'sd255) return {1'b0, 8'hFF, 23'b0};
    return {1'b0, e[7:0], 23'b0};
  endfunction

endpackage

>>> sv/fep_op.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_op: one float operation as two pipeline stages
// First stage forms the exact product or aligned sum, second rounds it.
// ----------------------------------------------------------------------------
module fep_op #(
  parameter fep_pkg::step_e STEP = fep_pkg::ST_LOG2E
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  fep_pkg::ctx_t ctx_i,
  output logic          vld_o,
  output fep_pkg::ctx_t ctx_o
);
  import fep_pkg::*;

  logic [31:0] opa, opb, res;
  logic        is_mul;
  raw_t        raw_d, raw_q;
  ctx_t        mid_q, ctx_d, ctx_q;
  logic        mvld_q, vld_q;

  // operand select for this step
  always_comb begin
    opa    = ctx_i.y;
    opb    = ctx_i.g;
    is_mul = 1'b1;
    unique case (STEP) inside
      ST_LOG2E: begin opa = ctx_i.x;  opb = Log2E; end
      ST_LN2:   begin opa = ctx_i.fx; opb = Ln2; end
      ST_SUB: begin
        opa = ctx_i.x; opb = {~ctx_i.t[31], ctx_i.t[30:0]}; is_mul = 1'b0;
      end
      ST_SQR:   begin opa = ctx_i.g;  opb = ctx_i.g; end
      ST_M0:    begin opa = CoefP0;   opb = ctx_i.g; end
      ST_M1, ST_M2, ST_M3, ST_M4: begin opa = ctx_i.y; opb = ctx_i.g; end
      ST_A1:    begin opa = ctx_i.t;  opb = CoefP1; is_mul = 1'b0; end
      ST_A2:    begin opa = ctx_i.t;  opb = CoefP2; is_mul = 1'b0; end
      ST_A3:    begin opa = ctx_i.t;  opb = CoefP3; is_mul = 1'b0; end
      ST_A4:    begin opa = ctx_i.t;  opb = CoefP4; is_mul = 1'b0; end
      ST_A5:    begin opa = ctx_i.t;  opb = CoefP5; is_mul = 1'b0; end
      ST_POLY:  begin opa = ctx_i.y;  opb = ctx_i.g2; end
      ST_ADDG:  begin opa = ctx_i.t;  opb = ctx_i.g; is_mul = 1'b0; end
      ST_ADD1:  begin opa = ctx_i.y;  opb = FpOne;   is_mul = 1'b0; end
      ST_SCALE: begin opa = ctx_i.y;  opb = fp_scale(ctx_i.n); end
      default:  ;
    endcase
    raw_d = is_mul ? fp_mul(opa, opb) : fp_add(opa, opb);
  end

  // first stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
    end else begin
      mvld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
    mid_q <= ctx_i;
  end

  // round and write the destination field
  always_comb begin
    res   = fp_round(raw_q);
    ctx_d = mid_q;
    unique case (STEP) inside
      ST_LOG2E, ST_LN2, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_POLY: ctx_d.t = res;
      ST_SUB:  ctx_d.g  = res;
      ST_SQR:  ctx_d.g2 = res;
      ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_ADDG, ST_ADD1, ST_SCALE: ctx_d.y = res;
      default: ;
    endcase
  end

  // second stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= mvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
  end

  assign vld_o = vld_q;
  assign ctx_o = ctx_q;

endmodule

>>> sv/fep_rnd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fep_rnd: integer exponent stage
// Rounds x*log2(e) to the nearest integer n, ties to even, and converts n back to float.
// ----------------------------------------------------------------------------
module fep_rnd (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  fep_pkg::ctx_t ctx_i,
  output logic          vld_o,
  output fep_pkg::ctx_t ctx_o
);
  import fep_pkg::*;

  ctx_t ctx_d, ctx_q;
  logic vld_q;

  // n and its float image
  always_comb begin
    ctx_d    = ctx_i;
    ctx_d.n  = fp_rne(ctx_i.t);
    ctx_d.fx = fp_from_int(ctx_d.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
  end

  assign vld_o = vld_q;
  assign ctx_o = ctx_q;

endmodule

>>> sv/float_exp_polynomial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_exp_polynomial: single-precision exponential
// Clamp, range reduction by ln2, fifth-degree polynomial, scale by 2^n.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, arg_bits_i[31:0]  | word taken when start && !busy
//  output  | done_o, exp_bits_o[31:0]       | one-cycle strobe, no back-pressure
//
//  the path holds an input register, 18 float steps of two stages each
//  (product or aligned sum, then round) and one integer-rounding stage
//  a new word is taken every cycle; busy stays low since nothing stalls
//  reset clears the valid bits of every stage, data registers are not reset
// ----------------------------------------------------------------------------
module float_exp_polynomial (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] arg_bits_i,
  output logic        done_o,
  output logic [31:0] exp_bits_o
);
  import fep_pkg::*;

  localparam int NumTail = int'(ST_SCALE) - int'(ST_LN2) + 1;
  localparam int Latency = 1 + 2 + 1 + 2 * NumTail;

  ctx_t in_d, in_q;
  logic in_vld_q;
  ctx_t head_ctx, rnd_ctx;
  logic head_vld, rnd_vld;
  ctx_t tail_ctx [NumTail+1];
  logic tail_vld [NumTail+1];

  assign busy = 1'b0;

  // input register with clamp
  always_comb begin
    in_d   = '0;
    in_d.x = fp_clamp(arg_bits_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // t = x * log2(e)
  fep_op #(.STEP(ST_LOG2E)) u_head (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .vld_i (in_vld_q), .ctx_i(in_q),
    .vld_o (head_vld), .ctx_o(head_ctx)
  );

  // n = round(t)
  fep_rnd u_rnd (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .vld_i (head_vld), .ctx_i(head_ctx),
    .vld_o (rnd_vld), .ctx_o(rnd_ctx)
  );

  assign tail_ctx[0] = rnd_ctx;
  assign tail_vld[0] = rnd_vld;

  // reduction, polynomial and scaling steps
  for (genvar gi = 0; gi < NumTail; gi++) begin : g_tail
    fep_op #(.STEP(step_e'(int'(ST_LN2) + gi))) u_op (
      .clk_i (clk_i), .rst_ni(rst_ni),
      .vld_i (tail_vld[gi]), .ctx_i(tail_ctx[gi]),
      .vld_o (tail_vld[gi+1]), .ctx_o(tail_ctx[gi+1])
    );
  end

  assign done_o     = tail_vld[NumTail];
  assign exp_bits_o = tail_ctx[NumTail].y;

  // a result word only follows an accepted word
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without matching input word");

  // the exponential is never negative
  a_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !exp_bits_o[31])
    else $error("negative result");

  // no nan ever leaves the block
  a_no_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !((exp_bits_o[30:23] == 8'hFF) && (exp_bits_o[22:0] != 23'd0)))
    else $error("nan result");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for float_exp_polynomial
// Drives single-precision words with random idle bursts and checks each
// result against a bit-exact exponential predictor that works in doubles
// and rounds to single precision after every operation.
// ----------------------------------------------------------------------------
module tb;

  // expected exponentials and the predictor that produces them
  class exp_scoreboard;
    logic [31:0] exp_q[$];
    int          errors;
    int          checked;
    int          n_inf, n_zero, n_sub;
    logic [31:0] clamp_hi;
    real         log2e_r, ln2_r;
    real         coef[6];

    function new();
      clamp_hi = to_single(88.3762626647949);
      log2e_r  = rnd(1.44269504088896341);
      ln2_r    = rnd(0.693147180559945);
      coef[0]  = rnd(1.9875691500E-4);
      coef[1]  = rnd(1.3981999507E-3);
      coef[2]  = rnd(8.3334519073E-3);
      coef[3]  = rnd(4.1665795894E-2);
      coef[4]  = rnd(1.6666665459E-1);
      coef[5]  = rnd(5.0000001201E-1);
    endfunction

    // double to single bits, round to nearest even, subnormals kept
    function logic [31:0] to_single(real r);
      logic [63:0] d, mm, q, rem, half;
      logic        s, up;
      int          se, sh;
      d  = $realtobits(r);
      s  = d[63];
      if (d[62:52] == 11'd0) return {s, 31'b0};
      if (d[62:52] == 11'h7FF) return {s, 8'hFF, 23'b0};
      se = int'(d[62:52]) - 1023 + 127;
      mm = {11'b0, 1'b1, d[51:0]};
      sh = (se >= 1) ? 29 : 29 + 1 - se;
      if (sh > 63) sh = 63;
      q    = mm >> sh;
      rem  = mm - (q << sh);
      half = 64'd1 << (sh - 1);
      up   = (rem > half) || ((rem == half) && q[0]);
      q    = q + 64'(up);
      if (se >= 1) begin
        if (q[24]) begin
          q  = q >> 1;
          se = se + 1;
        end
        if (se >= 255) return {s, 8'hFF, 23'b0};
        return {s, 8'(se), q[22:0]};
      end
      // a carry out of the subnormal range lands in the exponent lsb
      return {s, q[30:0]};
    endfunction

    // single bits to double, exact
    function real to_real(logic [31:0] b);
      real v;
      if (b[30:23] == 8'd0) begin
        v = real'(int'(b[22:0])) * (2.0 ** (-149));
        return b[31] ? -v : v;
      end
      return $bitstoreal({b[31], 11'(int'(b[30:23]) + 896), b[22:0], 29'b0});
    endfunction

    function real rnd(real r);
      return to_real(to_single(r));
    endfunction

    // nearest integer, ties to even
    function int nearest_even(real v);
      int  i;
      real fr;
      i  = $rtoi(v);
      fr = v - i;
      if (fr > 0.5) i = i + 1;
      else if (fr < -0.5) i = i - 1;
      else if (fr == 0.5) begin
        if (i % 2 != 0) i = i + 1;
      end else if (fr == -0.5) begin
        if (i % 2 != 0) i = i - 1;
      end
      return i;
    endfunction

    // expected exponential of one input word
    function logic [31:0] exp_of(logic [31:0] a);
      logic [31:0] xb;
      real         x, g, g2, y;
      int          n, e;
      xb = a;
      if (a[30:23] == 8'hFF && a[22:0] != 23'd0) xb = clamp_hi;
      else if (a[30:0] > clamp_hi[30:0]) xb = {a[31], clamp_hi[30:0]};
      x  = to_real(xb);
      n  = nearest_even(rnd(x * log2e_r));
      g  = rnd(x - rnd(real'(n) * ln2_r));
      g2 = rnd(g * g);
      y  = coef[0];
      for (int k = 1; k < 6; k++) y = rnd(rnd(y * g) + coef[k]);
      y = rnd(rnd(y * g2) + g);
      y = rnd(y + 1.0);
      e = n + 127;
      if (e <= 0) return 32'd0;
      if (e >= 255) return 32'h7F800000;
      return to_single(y * (2.0 ** n));
    endfunction

    function void note_arg(logic [31:0] a);
      exp_q.push_back(exp_of(a));
    endfunction

    function void check_exp(logic [31:0] got);
      logic [31:0] want;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = exp_q.pop_front();
      checked++;
      if (got == 32'h7F800000) n_inf++;
      if (got == 32'd0) n_zero++;
      if (got[30:23] == 8'd0 && got[22:0] != 23'd0) n_sub++;
      if (got !== want) begin
        $display("%0t: exp_bits mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] arg_bits_i;
  logic        done_o;
  logic [31:0] exp_bits_o;

  exp_scoreboard sb;
  int            cycles;
  int            n_items;

  localparam int NumRandom = 1500;
  localparam int Latency   = 38;
  localparam int CycleLimit = 400000;

  float_exp_polynomial uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .arg_bits_i (arg_bits_i),
    .done_o     (done_o),
    .exp_bits_o (exp_bits_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watch both sides at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_arg(arg_bits_i);
      if (done_o) sb.check_exp(exp_bits_o);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // send one word, with an optional idle burst ahead of it
  task automatic send_word(logic [31:0] w, bit may_idle);
    bit taken;
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    start      <= 1'b1;
    arg_bits_i <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    n_items++;
  endtask

  // random word: raw bits, ordinary range, or near the clamp bounds
  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom;
    if (sel < 8) return {1'($urandom), 8'($urandom_range(100, 133)), 23'($urandom)};
    if ($urandom_range(0, 1) == 1) return {1'($urandom), 15'h42B0, 16'($urandom)};
    return {1'($urandom), 15'h42AE, 16'($urandom)};
  endfunction

  logic [31:0] directed[$] = '{
    32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
    32'hFFFFFFFF, 32'h7F800001, 32'h42B0C0A5, 32'hC2B0C0A5, 32'h42B0C0A6,
    32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001, 32'h807FFFFF, 32'h3F800000,
    32'hBF800000, 32'h3EB17218, 32'hC2AE0000, 32'hC2AEAC50, 32'hC2B00000,
    32'h42B00000, 32'h41200000, 32'hC1200000
  };

  initial begin
    int wait_cnt;
    sb         = new();
    cycles     = 0;
    n_items    = 0;
    start      = 1'b0;
    arg_bits_i = 32'd0;
    rst_ni     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner words first
    foreach (directed[i]) send_word(directed[i], 1'b1);

    // random words, no idling in the final stretch
    for (int i = 0; i < NumRandom; i++) send_word(rand_word(), i < NumRandom - 200);
    start <= 1'b0;

    // drain, then a little extra for stray words
    wait_cnt = 0;
    while (sb.exp_q.size() != 0 && wait_cnt < 10 * Latency) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.exp_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sb.exp_q.size());
      sb.errors++;
    end

    $display("sent %0d words (corners, NaN, infinities, subnormals, clamp edges)", n_items);
    $display("checked %0d results: %0d inf, %0d zero, %0d subnormal",
             sb.checked, sb.n_inf, sb.n_zero, sb.n_sub);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
